[hdl/vector_unpack_format_expander_macros.svh]
// assertion macros for the vector unpack format expander
`ifndef VECTOR_UNPACK_FORMAT_EXPANDER_MACROS_SVH
`define VECTOR_UNPACK_FORMAT_EXPANDER_MACROS_SVH

`ifndef SYNTHESIS

// antecedent implies consequent in the same cycle
`define VUFE_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define VUFE_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons) \
  lbl: assert property (@(posedge clk_s) disable iff (!rstn_s) (ante) |=> (cons)) \
    else $error("assertion failed");

`else

`define VUFE_ASSERT_SAME(lbl, clk_s, rstn_s, ante, cons)
`define VUFE_ASSERT_NEXT(lbl, clk_s, rstn_s, ante, cons)

`endif

`endif

[hdl/vufe_pkg.sv]
// shared types and format codes of the vector unpack format expander
`timescale 1ns / 1ps

package vufe_pkg;

  // element size codes, req_type bits 1:0
  localparam logic [1:0] SIZE_32 = 2'd0;
  localparam logic [1:0] SIZE_16 = 2'd1;
  localparam logic [1:0] SIZE_8  = 2'd2;
  localparam logic [1:0] SIZE_5  = 2'd3;

  // vector count codes, req_type bits 3:2
  localparam logic [1:0] CNT_S  = 2'd0;
  localparam logic [1:0] CNT_V2 = 2'd1;
  localparam logic [1:0] CNT_V3 = 2'd2;
  localparam logic [1:0] CNT_V4 = 2'd3;

  // one input transaction
  typedef struct packed {
    logic [3:0]  req_type;
    logic        unsigned_mode;
    logic [63:0] src_low;
    logic [63:0] src_high;
  } req_t;

  // one result transaction
  typedef struct packed {
    logic [31:0] lane_x;
    logic [31:0] lane_y;
    logic [31:0] lane_z;
    logic [31:0] lane_w;
    logic        format_invalid;
  } res_t;

endpackage

[hdl/vector_unpack_format_expander.sv]
// Vector unpack format expander, top level.
// Input channel: in_valid/in_ready carry one transaction of format code,
// sign mode and 128 source bits (in_src_low, in_src_high).
// Output channel: out_valid/out_ready carry one four-lane vector of 32-bit
// words plus out_format_invalid, one result per input transaction.
// A transaction loads into the input register at the accepting edge and
// moves to the result register once that register is free; out_valid
// rises when the result register holds it.
// Throughput: one transaction per cycle while out_ready is high; both
// registers advance together and the input register refills in the same
// cycle it is drained. On a receiver stall the result register holds its
// transaction; the input register can take one more, then in_ready drops.
// in_ready follows out_ready combinationally through the two stages.
// Reset (rst_n low, synchronous) empties both stages; payload registers
// are not cleared. There is no configuration and no other internal state.
`timescale 1ns / 1ps
`include "vector_unpack_format_expander_macros.svh"

module vector_unpack_format_expander (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_req_type,
  input  logic        in_unsigned_mode,
  input  logic [63:0] in_src_low,
  input  logic [63:0] in_src_high,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_lane_x,
  output logic [31:0] out_lane_y,
  output logic [31:0] out_lane_z,
  output logic [31:0] out_lane_w,
  output logic        out_format_invalid
);

  logic           s1_vld_r, s1_vld_nxt;
  vufe_pkg::req_t s1_req_r;
  logic           out_vld_r, out_vld_nxt;
  vufe_pkg::res_t out_res_r;
  vufe_pkg::res_t exp_res;
  logic           out_adv;
  logic           s1_adv;
  logic           in_acc;
  logic           lanes_zero;

  // stage advance control
  assign out_adv  = !out_vld_r || out_ready;
  assign s1_adv   = s1_vld_r && out_adv;
  assign in_ready = !s1_vld_r || out_adv;
  assign in_acc   = in_valid && in_ready;

  assign s1_vld_nxt  = in_acc || (s1_vld_r && !out_adv);
  assign out_vld_nxt = s1_adv || (out_vld_r && !out_ready);

  // valid flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
    end else begin
      s1_vld_r  <= s1_vld_nxt;
      out_vld_r <= out_vld_nxt;
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_req_r.req_type      <= in_req_type;
      s1_req_r.unsigned_mode <= in_unsigned_mode;
      s1_req_r.src_low       <= in_src_low;
      s1_req_r.src_high      <= in_src_high;
    end
  end

  // expansion logic
  vufe_expand u_expand (
    .req (s1_req_r),
    .res (exp_res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_res_r <= exp_res;
    end
  end

  assign out_valid          = out_vld_r;
  assign out_lane_x         = out_res_r.lane_x;
  assign out_lane_y         = out_res_r.lane_y;
  assign out_lane_z         = out_res_r.lane_z;
  assign out_lane_w         = out_res_r.lane_w;
  assign out_format_invalid = out_res_r.format_invalid;

  // all four result lanes zero
  assign lanes_zero = (out_lane_x == 32'd0) && (out_lane_y == 32'd0) &&
                      (out_lane_z == 32'd0) && (out_lane_w == 32'd0);

  // checks
  `VUFE_ASSERT_SAME(a_invalid_zero, clk, rst_n, out_valid && out_format_invalid, lanes_zero)
  `VUFE_ASSERT_NEXT(a_accept_fills, clk, rst_n, in_acc, s1_vld_r)
  `VUFE_ASSERT_NEXT(a_stage_moves, clk, rst_n, s1_adv, out_vld_r)
  `VUFE_ASSERT_SAME(a_empty_ready, clk, rst_n, !s1_vld_r, in_ready)

endmodule

[hdl/vufe_expand.sv]
// combinational format decode and lane expansion
`timescale 1ns / 1ps

module vufe_expand (
  input  vufe_pkg::req_t req,
  output vufe_pkg::res_t res
);

  // element idx of the source, extended to 32 bits
  function automatic logic [31:0] elem_f(input logic [1:0]   size,
                                         input logic [127:0] src,
                                         input logic [1:0]   idx,
                                         input logic         usn);
    logic [15:0] h;
    logic [7:0]  b;
    logic [31:0] v;
    h = src[{1'b0, idx, 4'b0000} +: 16];
    b = src[{2'b00, idx, 3'b000} +: 8];
    case (size)
      vufe_pkg::SIZE_32: v = src[{idx, 5'b00000} +: 32];
      vufe_pkg::SIZE_16: v = {{16{h[15] & ~usn}}, h};
      default:           v = {{24{b[7] & ~usn}}, b};
    endcase
    return v;
  endfunction

  logic [1:0]   size;
  logic [1:0]   count;
  logic [127:0] src;
  logic [31:0]  e0, e1, e2, e3;
  logic [15:0]  d;

  assign size  = req.req_type[1:0];
  assign count = req.req_type[3:2];
  assign src   = {req.src_high, req.src_low};
  assign d     = req.src_low[15:0];

  // the four candidate elements
  assign e0 = elem_f(size, src, 2'd0, req.unsigned_mode);
  assign e1 = elem_f(size, src, 2'd1, req.unsigned_mode);
  assign e2 = elem_f(size, src, 2'd2, req.unsigned_mode);
  assign e3 = elem_f(size, src, 2'd3, req.unsigned_mode);

  // lane selection by size and count
  always_comb begin
    res = '0;
    if (size == vufe_pkg::SIZE_5) begin
      if (count == vufe_pkg::CNT_V4) begin
        // 5551 colour to 8-bit channels
        res.lane_x = {24'd0, d[4:0], 3'b000};
        res.lane_y = {24'd0, d[9:5], 3'b000};
        res.lane_z = {24'd0, d[14:10], 3'b000};
        res.lane_w = {24'd0, d[15], 7'd0};
      end else begin
        res.format_invalid = 1'b1;
      end
    end else begin
      unique case (count)
        vufe_pkg::CNT_S: begin
          res.lane_x = e0;
          res.lane_y = e0;
          res.lane_z = e0;
          res.lane_w = e0;
        end
        vufe_pkg::CNT_V2: begin
          res.lane_x = e0;
          res.lane_y = e1;
          res.lane_z = e0;
          res.lane_w = (size == vufe_pkg::SIZE_32) ? 32'd0 : e1;
        end
        vufe_pkg::CNT_V3: begin
          res.lane_x = e0;
          res.lane_y = e1;
          res.lane_z = e2;
          res.lane_w = 32'd0;
        end
        default: begin
          res.lane_x = e0;
          res.lane_y = e1;
          res.lane_z = e2;
          res.lane_w = e3;
        end
      endcase
    end
  end

endmodule
